// ===== design/hbkd_pkg.sv =====
// Package for the HID boot keyboard report decoder.
// Holds constants, shared types and the keymap / keypad / extras lookup functions.
// No dependencies.
`default_nettype none

package hbkd_pkg;

  localparam int unsigned MaxSlots    = 6;
  localparam int unsigned KeySlotsDef = 6;
  localparam int unsigned SDataW      = 64;
  localparam int unsigned MDataW      = 32;

  // input transaction layout
  localparam int unsigned LenLsb  = 0;
  localparam int unsigned ModLsb  = 7;
  localparam int unsigned SlotLsb = 15;

  localparam logic [6:0] LenBoot   = 7'd8;
  localparam logic [6:0] LenBootId = 7'd9;

  localparam logic [7:0] CodeCaps   = 8'h39;
  localparam logic [7:0] CodeScroll = 8'h47;
  localparam logic [7:0] CodeNum    = 8'h53;
  localparam logic [7:0] PadFirst   = 8'h54;
  localparam logic [7:0] PadLast    = 8'h63;
  localparam logic [7:0] KeymapEnd  = 8'h39;

  localparam logic [2:0] LockNum    = 3'b001;
  localparam logic [2:0] LockCaps   = 3'b010;
  localparam logic [2:0] LockScroll = 3'b100;

  localparam logic [3:0] ModNoShift = 4'hD;
  localparam logic [3:0] ModShift   = 4'h2;

  localparam logic [1:0] MapPlain = 2'd0;
  localparam logic [1:0] MapCtrl  = 2'd1;
  localparam logic [1:0] MapShift = 2'd2;

  localparam logic EvPress   = 1'b0;
  localparam logic EvRelease = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic [7:0] code;
    logic [7:0] modifier;
    logic       num_on;
    logic       caps_on;
  } map_req_t;

  // keypad with num lock off; bit 7 marks a stand-in for a navigation code
  function automatic logic [7:0] pad_off(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'h2F;
      4'd1:    v = 8'h2A;
      4'd2:    v = 8'h2D;
      4'd3:    v = 8'h2B;
      4'd4:    v = 8'h0A;
      4'd5:    v = 8'hCD;
      4'd6:    v = 8'hD1;
      4'd7:    v = 8'hCE;
      4'd8:    v = 8'hD0;
      4'd9:    v = 8'h00;
      4'd10:   v = 8'hCF;
      4'd11:   v = 8'hCA;
      4'd12:   v = 8'hD2;
      4'd13:   v = 8'hCB;
      4'd14:   v = 8'hC9;
      default: v = 8'hCC;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pad_on(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'h2F;
      4'd1:    v = 8'h2A;
      4'd2:    v = 8'h2D;
      4'd3:    v = 8'h2B;
      4'd4:    v = 8'h0A;
      4'd5:    v = 8'h31;
      4'd6:    v = 8'h32;
      4'd7:    v = 8'h33;
      4'd8:    v = 8'h34;
      4'd9:    v = 8'h35;
      4'd10:   v = 8'h36;
      4'd11:   v = 8'h37;
      4'd12:   v = 8'h38;
      4'd13:   v = 8'h39;
      4'd14:   v = 8'h30;
      default: v = 8'h2E;
    endcase
    return v;
  endfunction

  // {hit, char}
  function automatic logic [8:0] extra_map(input logic [7:0] code);
    logic [8:0] v;
    case (code)
      8'd40:   v = {1'b1, 8'h0A};
      8'd41:   v = {1'b1, 8'h1B};
      8'd43:   v = {1'b1, 8'h09};
      8'd82:   v = {1'b1, 8'hDA};
      8'd81:   v = {1'b1, 8'hD9};
      8'd80:   v = {1'b1, 8'hD8};
      8'd79:   v = {1'b1, 8'hD7};
      8'd73:   v = {1'b1, 8'hD1};
      8'd76:   v = {1'b1, 8'hD4};
      8'd75:   v = {1'b1, 8'hD3};
      8'd78:   v = {1'b1, 8'hD6};
      8'd74:   v = {1'b1, 8'hD2};
      8'd77:   v = {1'b1, 8'hD5};
      8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63,
      8'd64, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69:
               v = {1'b1, code + 8'h88};  // F1..F12
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] plain_map(input logic [5:0] code);
    logic [7:0] v;
    if (code >= 6'd4 && code <= 6'd29) begin
      v = 8'h5D + {2'b00, code};
    end else begin
      case (code)
        6'd30:   v = 8'h31;
        6'd31:   v = 8'h32;
        6'd32:   v = 8'h33;
        6'd33:   v = 8'h34;
        6'd34:   v = 8'h35;
        6'd35:   v = 8'h36;
        6'd36:   v = 8'h37;
        6'd37:   v = 8'h38;
        6'd38:   v = 8'h39;
        6'd39:   v = 8'h30;
        6'd40:   v = 8'h0A;
        6'd41:   v = 8'h1B;
        6'd42:   v = 8'h08;
        6'd43:   v = 8'h09;
        6'd44:   v = 8'h20;
        6'd45:   v = 8'h2D;
        6'd46:   v = 8'h3D;
        6'd47:   v = 8'h5B;
        6'd48:   v = 8'h5D;
        6'd49:   v = 8'h5C;
        6'd50:   v = 8'h23;
        6'd51:   v = 8'h3B;
        6'd52:   v = 8'h27;
        6'd54:   v = 8'h2C;
        6'd55:   v = 8'h2E;
        6'd56:   v = 8'h2F;
        default: v = 8'h00;
      endcase
    end
    return v;
  endfunction

  function automatic logic [7:0] ctrl_map(input logic [5:0] code);
    logic [7:0] v;
    if (code >= 6'd4 && code <= 6'd29) v = {2'b00, code} - 8'd3;
    else                                v = 8'h00;
    return v;
  endfunction

  function automatic logic [7:0] shift_map(input logic [5:0] code);
    logic [7:0] v;
    if (code >= 6'd4 && code <= 6'd29) begin
      v = 8'h3D + {2'b00, code};
    end else begin
      case (code)
        6'd30:   v = 8'h21;
        6'd31:   v = 8'h40;
        6'd32:   v = 8'h23;
        6'd33:   v = 8'h24;
        6'd34:   v = 8'h25;
        6'd35:   v = 8'h5E;
        6'd36:   v = 8'h26;
        6'd37:   v = 8'h2A;
        6'd38:   v = 8'h28;
        6'd39:   v = 8'h29;
        6'd46:   v = 8'h2B;
        6'd47:   v = 8'h7B;
        6'd48:   v = 8'h7D;
        6'd49:   v = 8'h7C;
        6'd50:   v = 8'h7E;
        6'd51:   v = 8'h3A;
        6'd52:   v = 8'h22;
        6'd54:   v = 8'h3C;
        6'd55:   v = 8'h3E;
        6'd56:   v = 8'h3F;
        default: v = 8'h00;
      endcase
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/hbkd_match.sv =====
// Shared key compare unit: is a usage code present in any slot of a report.
// Depends on hbkd_pkg.
`default_nettype none

module hbkd_match #(
  parameter int unsigned KeySlots = hbkd_pkg::KeySlotsDef
) (
  input  logic [7:0]                code_i,
  input  logic [KeySlots-1:0][7:0]  slots_i,
  output logic                      hit_o
);
  import hbkd_pkg::*;

  logic [KeySlots-1:0] eq;

  always_comb begin
    for (int unsigned i = 0; i < KeySlots; i++) begin
      eq[i] = (slots_i[i] == code_i);
    end
  end

  assign hit_o = |eq;

endmodule

`default_nettype wire

// ===== design/hbkd_mapper.sv =====
// Maps a usage code to ASCII or a special code: keypad, extras, then keymap.
// Depends on hbkd_pkg.
`default_nettype none

module hbkd_mapper (
  input  hbkd_pkg::map_req_t req_i,
  output logic [7:0]         char_o
);
  import hbkd_pkg::*;

  logic [3:0] pad_idx;
  logic [7:0] off_val;
  logic [7:0] code_eff;
  logic [8:0] extra;
  logic [3:0] mods;

  always_comb begin
    pad_idx  = 4'(req_i.code - PadFirst);
    off_val  = pad_off(pad_idx);
    code_eff = req_i.code;
    mods     = req_i.modifier[3:0] | req_i.modifier[7:4];
    if ((mods & ModNoShift) == 4'h0 && req_i.caps_on) mods = mods ^ ModShift;
    char_o   = 8'h00;

    if (req_i.code >= PadFirst && req_i.code <= PadLast && !req_i.num_on && off_val[7]) begin
      code_eff = {1'b0, off_val[6:0]};   // keypad stands in for a nav key
    end
    extra = extra_map(code_eff);

    if (req_i.code >= PadFirst && req_i.code <= PadLast && req_i.num_on) begin
      char_o = pad_on(pad_idx);
    end else if (req_i.code >= PadFirst && req_i.code <= PadLast && !off_val[7]) begin
      char_o = off_val;
    end else if (extra[8]) begin
      char_o = extra[7:0];
    end else if (code_eff < KeymapEnd) begin
      case (mods)
        {2'b00, MapPlain}: char_o = plain_map(code_eff[5:0]);
        {2'b00, MapCtrl}:  char_o = ctrl_map(code_eff[5:0]);
        {2'b00, MapShift}: char_o = shift_map(code_eff[5:0]);
        default:           char_o = 8'h00;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/hid_boot_keyboard_report_decoder_unit.sv =====
// HID boot keyboard report decoder, top level: sequencer, state and output register.
// Depends on hbkd_pkg, hbkd_match, hbkd_mapper.
//
// Takes one boot keyboard report per input transaction and emits one output
// transaction per key event: presses of new keys in slot order, then releases of
// keys that have gone, in slot order; tlast marks the final event of a report.
// Reports whose length is not 8 or 9 are dropped without touching state. A report
// occupies the block for a press pass and a release pass over all KEY_SLOTS slots (one
// key compared against a whole slot set per cycle through the shared compare unit),
// then for the emission of its events, one at a time; a new report is accepted only
// in the idle state, after its last event, if any, has been loaded for output.
// A dropped report takes one cycle. Output backpressure stalls the event cycles.
`default_nettype none

module hid_boot_keyboard_report_decoder_unit #(
  parameter int unsigned KEY_SLOTS = hbkd_pkg::KeySlotsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // report_length[6:0], modifier_bits[14:7], slot_code_0..5[62:15], zero[63]
  input  logic [hbkd_pkg::SDataW-1:0] s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // raw_code[7:0], mapped_char[15:8], modifier_used[23:16], lock_leds[26:24],
  // leds_changed[27], zero[31:28]
  output logic [hbkd_pkg::MDataW-1:0] m_axis_tdata_o,
  // event_kind
  output logic                        m_axis_tuser_o,
  // last_event
  output logic                        m_axis_tlast_o
);
  import hbkd_pkg::*;

  localparam int unsigned IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int unsigned EW = 2 * KEY_SLOTS;

  state_e                    state_q, state_d;
  logic [IW-1:0]             slot_q;
  logic                      phase_q;
  logic                      alive_q;
  logic [KEY_SLOTS-1:0]      press_q;
  logic [KEY_SLOTS-1:0]      rel_q;
  logic [KEY_SLOTS-1:0][7:0] cur_q;
  logic [KEY_SLOTS-1:0][7:0] prev_q;
  logic [7:0]                mod_q;
  logic [7:0]                prev_mod_q;
  logic [2:0]                lock_q;

  logic                      out_valid_q;
  logic                      out_kind_q;
  logic [7:0]                out_raw_q;
  logic [7:0]                out_char_q;
  logic [7:0]                out_mod_q;
  logic [2:0]                out_leds_q;
  logic                      out_chg_q;
  logic                      out_last_q;

  logic                      s_fire;
  logic                      len_ok;
  logic [6:0]                in_len;

  // scan datapath
  logic [7:0]                scan_code;
  logic [KEY_SLOTS-1:0][7:0] scan_set;
  logic                      scan_hit;
  logic                      scan_live;
  logic                      last_slot;

  // emit datapath
  logic [EW-1:0]             ev;
  logic [EW-1:0]             ev_low;
  logic [EW-1:0]             ev_rest;
  logic                      ev_rel;
  logic [KEY_SLOTS-1:0]      ev_slot;
  logic [7:0]                sel_code;
  logic [7:0]                sel_mod;
  logic [7:0]                sel_char;
  logic [2:0]                toggle;
  logic                      out_free;
  logic                      load;
  map_req_t                  map_req;

  assign in_len          = s_axis_tdata_i[LenLsb +: 7];
  assign len_ok          = (in_len == LenBoot) || (in_len == LenBootId);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;

  // ---- scan: one key against the other report's slots per cycle ----
  assign scan_code = phase_q ? prev_q[slot_q] : cur_q[slot_q];
  assign scan_set  = phase_q ? cur_q : prev_q;
  assign scan_live = alive_q && (scan_code != 8'h00);
  assign last_slot = (slot_q == IW'(KEY_SLOTS - 1));

  hbkd_match #(.KeySlots(KEY_SLOTS)) u_match (
    .code_i  (scan_code),
    .slots_i (scan_set),
    .hit_o   (scan_hit)
  );

  // ---- emit: lowest pending event, presses before releases ----
  assign ev      = {rel_q, press_q};
  assign ev_low  = ev & ((~ev) + {{(EW-1){1'b0}}, 1'b1});
  assign ev_rest = ev & ~ev_low;
  assign ev_rel  = |ev_low[EW-1:KEY_SLOTS];
  assign ev_slot = ev_low[KEY_SLOTS-1:0] | ev_low[EW-1:KEY_SLOTS];

  always_comb begin
    sel_code = 8'h00;
    for (int unsigned i = 0; i < KEY_SLOTS; i++) begin
      if (ev_slot[i]) sel_code = sel_code | (ev_rel ? prev_q[i] : cur_q[i]);
    end
  end

  assign sel_mod = ev_rel ? prev_mod_q : mod_q;

  assign map_req = '{code: sel_code, modifier: sel_mod,
                     num_on: lock_q[0], caps_on: lock_q[1]};

  hbkd_mapper u_mapper (
    .req_i  (map_req),
    .char_o (sel_char)
  );

  always_comb begin
    toggle = 3'b000;
    if (ev_rel) begin
      if (sel_code == CodeNum)         toggle = LockNum;
      else if (sel_code == CodeCaps)   toggle = LockCaps;
      else if (sel_code == CodeScroll) toggle = LockScroll;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign load     = (state_q == S_EMIT) && (ev != '0) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_fire && len_ok) state_d = S_SCAN;
      S_SCAN: if (phase_q && last_slot) state_d = S_EMIT;
      S_EMIT: if (ev == '0 || (load && ev_rest == '0)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      slot_q     <= '0;
      phase_q    <= 1'b0;
      alive_q    <= 1'b0;
      press_q    <= '0;
      rel_q      <= '0;
      prev_q     <= '0;
      prev_mod_q <= 8'h00;
      lock_q     <= 3'b000;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          slot_q  <= '0;
          phase_q <= 1'b0;
          alive_q <= 1'b1;
        end
        S_SCAN: begin
          if (phase_q) rel_q[slot_q]   <= scan_live && !scan_hit;
          else         press_q[slot_q] <= scan_live && !scan_hit;
          if (last_slot) begin
            slot_q  <= '0;
            phase_q <= 1'b1;
            alive_q <= 1'b1;   // release pass restarts at slot 0
          end else begin
            slot_q  <= slot_q + IW'(1);
            alive_q <= scan_live;
          end
        end
        S_EMIT: begin
          if (load) begin
            press_q <= ev_rest[KEY_SLOTS-1:0];
            rel_q   <= ev_rest[EW-1:KEY_SLOTS];
            lock_q  <= lock_q ^ toggle;
          end
          if (state_d == S_IDLE) begin
            prev_q     <= cur_q;
            prev_mod_q <= mod_q;
          end
        end
        default: ;
      endcase
    end
  end

  // report capture
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      mod_q <= s_axis_tdata_i[ModLsb +: 8];
      for (int unsigned i = 0; i < KEY_SLOTS; i++) begin
        cur_q[i] <= s_axis_tdata_i[SlotLsb + 8*i +: 8];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q <= ev_rel ? EvRelease : EvPress;
      out_raw_q  <= sel_code;
      out_char_q <= sel_char;
      out_mod_q  <= sel_mod;
      out_leds_q <= lock_q ^ toggle;
      out_chg_q  <= |toggle;
      out_last_q <= (ev_rest == '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'h0, out_chg_q, out_leds_q, out_mod_q, out_char_q, out_raw_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // ---- assertions ----
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !len_ok) |=> (state_q == S_IDLE))
    else $error("dropped report started a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && ev_rest == '0) |=> (state_q == S_IDLE && prev_q == $past(cur_q)))
    else $error("final event did not commit the report");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lock_q != $past(lock_q)) |-> $past(load && ev_rel))
    else $error("lock LEDs changed outside a release event");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> $onehot0(ev_low))
    else $error("event select not one-hot");

endmodule

`default_nettype wire

// ===== test/tb_hid_boot_keyboard_report_decoder_unit.sv =====
// Self-checking testbench for hid_boot_keyboard_report_decoder_unit.
// Directed reports, then keyboard-like random ones, checked against an in-bench decoder model.
// Depends on hbkd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_hid_boot_keyboard_report_decoder_unit;
  import hbkd_pkg::*;

  localparam int KeySlots  = KeySlotsDef;
  localparam int MaxEvents = 2 * KeySlots;

  typedef struct packed {
    logic [5:0][7:0] slots;   // slots[0] sits right above the modifier byte
    logic [7:0]      mods;
    logic [6:0]      len;
  } report_t;

  typedef struct packed {
    logic       event_kind;
    logic [7:0] raw_code;
    logic [7:0] mapped_char;
    logic [7:0] modifier_used;
    logic [2:0] lock_leds;
    logic       leds_changed;
    logic       last_event;
  } key_event_t;

  typedef enum logic [1:0] {
    CHK_MODEL,  // expectation from the decoder model
    CHK_ONE,    // single event typed into the table
    CHK_NONE    // report is dropped, nothing comes out
  } chk_e;

  typedef struct packed {
    report_t    rpt;
    chk_e       how;
    key_event_t typed;
  } row_t;

  // keypad 0x54..0x63 with num lock on; the first five are the same with it off
  localparam logic [8*16-1:0] PadNumChars = {"/*-+", 8'h0A, "1234567890."};
  // keypad 0x59..0x63 with num lock off: navigation usage it stands for, 0 = no key
  localparam logic [8*11-1:0] PadNavCodes =
    {8'd77, 8'd81, 8'd78, 8'd80, 8'd0, 8'd79, 8'd74, 8'd82, 8'd75, 8'd73, 8'd76};
  localparam logic [8*10-1:0] DigitPlain = "1234567890";
  localparam logic [8*10-1:0] DigitShift = "!@#$%^&*()";
  // usages 0x28..0x38
  localparam logic [8*17-1:0] PunctPlain =
    {8'h0A, 8'h1B, 8'h08, 8'h09, " -=[]\\#;'", 8'h00, ",./"};
  localparam logic [8*17-1:0] PunctShift =
    {48'h0, "+{}|~:\"", 8'h00, "<>?"};

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [SDataW-1:0]   s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [MDataW-1:0]   m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                m_axis_tlast_o;

  // decoder model state
  logic [5:0][7:0] prev_keys;
  logic [7:0]      prev_mods;
  logic [2:0]      lock_leds_q;

  key_event_t  pending_events [$];
  row_t        directed_rows [$];
  logic [7:0]  held_keys [$];
  key_event_t  want_ev, got_ev;
  bit          failed;
  int unsigned src_calm, sink_calm, sink_hold;

  hid_boot_keyboard_report_decoder_unit #(
    .KEY_SLOTS(KeySlots)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int unsigned next_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 60);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] keymap_char(input logic [1:0] sel, input logic [7:0] c);
    if (c >= 8'd4 && c <= 8'd29) begin
      case (sel)
        MapPlain: return 8'h61 + c - 8'd4;
        MapCtrl:  return c - 8'd3;
        default:  return 8'h41 + c - 8'd4;
      endcase
    end
    if (sel == MapCtrl) return 8'h00;
    if (c >= 8'd30 && c <= 8'd39)
      return (sel == MapPlain) ? DigitPlain[8*(39-c) +: 8] : DigitShift[8*(39-c) +: 8];
    if (c >= 8'd40 && c <= 8'd56)
      return (sel == MapPlain) ? PunctPlain[8*(56-c) +: 8] : PunctShift[8*(56-c) +: 8];
    return 8'h00;
  endfunction

  // {hit, char} for enter, escape, tab, arrows, editing keys and F1..F12
  function automatic logic [8:0] special_key(input logic [7:0] c);
    case (c)
      8'd40:   return {1'b1, 8'h0A};
      8'd41:   return {1'b1, 8'h1B};
      8'd43:   return {1'b1, 8'h09};
      8'd73:   return {1'b1, 8'hD1};
      8'd74:   return {1'b1, 8'hD2};
      8'd75:   return {1'b1, 8'hD3};
      8'd76:   return {1'b1, 8'hD4};
      8'd77:   return {1'b1, 8'hD5};
      8'd78:   return {1'b1, 8'hD6};
      8'd79:   return {1'b1, 8'hD7};
      8'd80:   return {1'b1, 8'hD8};
      8'd81:   return {1'b1, 8'hD9};
      8'd82:   return {1'b1, 8'hDA};
      default: begin
        if (c >= 8'd58 && c <= 8'd69) return {1'b1, 8'hC2 + c - 8'd58};
        return 9'd0;
      end
    endcase
  endfunction

  function automatic logic [7:0] map_key(input logic [7:0] mods, input logic [7:0] code);
    logic [3:0] idx;
    logic [7:0] c;
    logic [8:0] hit_char;
    logic [3:0] m;
    c = code;
    if (c >= PadFirst && c <= PadLast) begin
      idx = 4'(c - PadFirst);
      if ((lock_leds_q & LockNum) != 0 || idx < 4'd5) return PadNumChars[8*(15-idx) +: 8];
      c = PadNavCodes[8*(15-idx) +: 8];
      if (c == 8'h00) return 8'h00;
    end
    hit_char = special_key(c);
    if (hit_char[8]) return hit_char[7:0];
    m = mods[3:0] | mods[7:4];
    // caps lock flips shift unless ctrl, alt or gui is down
    if ((m & ModNoShift) == 4'h0 && (lock_leds_q & LockCaps) != 0) m = m ^ ModShift;
    if (c < KeymapEnd && m <= {2'b00, MapShift}) return keymap_char(m[1:0], c);
    return 8'h00;
  endfunction

  function automatic bit is_held(input logic [7:0] code, input logic [5:0][7:0] keys);
    for (int k = 0; k < KeySlots; k++)
      if (keys[k] == code) return 1'b1;
    return 1'b0;
  endfunction

  // presses of new keys, then releases of gone keys; updates the model state
  task automatic decode_report(input report_t rpt, input bit keep);
    key_event_t ev;
    key_event_t evs [MaxEvents];
    int         n;
    logic [7:0] c;
    n = 0;
    if (rpt.len != LenBoot && rpt.len != LenBootId) return;
    for (int i = 0; i < KeySlots; i++) begin
      c = rpt.slots[i];
      if (c == 8'h00) break;
      if (!is_held(c, prev_keys)) begin
        ev = '0;
        ev.event_kind    = EvPress;
        ev.raw_code      = c;
        ev.mapped_char   = map_key(rpt.mods, c);
        ev.modifier_used = rpt.mods;
        ev.lock_leds     = lock_leds_q;
        evs[n] = ev;
        n++;
      end
    end
    for (int i = 0; i < KeySlots; i++) begin
      c = prev_keys[i];
      if (c == 8'h00) break;
      if (!is_held(c, rpt.slots)) begin
        ev = '0;
        ev.event_kind    = EvRelease;
        ev.raw_code      = c;
        ev.mapped_char   = map_key(prev_mods, c);  // mapped before the lock toggles
        ev.modifier_used = prev_mods;
        ev.leds_changed  = 1'b1;
        if (c == CodeNum) lock_leds_q = lock_leds_q ^ LockNum;
        else if (c == CodeCaps) lock_leds_q = lock_leds_q ^ LockCaps;
        else if (c == CodeScroll) lock_leds_q = lock_leds_q ^ LockScroll;
        else ev.leds_changed = 1'b0;
        ev.lock_leds = lock_leds_q;
        evs[n] = ev;
        n++;
      end
    end
    if (n > 0) evs[n-1].last_event = 1'b1;
    if (keep)
      for (int k = 0; k < n; k++) pending_events.push_back(evs[k]);
    prev_keys = rpt.slots;
    prev_mods = rpt.mods;
  endtask

  function automatic key_event_t single_event(input logic kind, input logic [7:0] raw,
                                              input logic [7:0] chr, input logic [7:0] mods,
                                              input logic [2:0] leds, input logic changed);
    return '{event_kind: kind, raw_code: raw, mapped_char: chr, modifier_used: mods,
             lock_leds: leds, leds_changed: changed, last_event: 1'b1};
  endfunction

  task automatic add_row(input logic [6:0] len, input logic [7:0] mods,
                         input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2,
                         input logic [7:0] s3, input logic [7:0] s4, input logic [7:0] s5,
                         input chk_e how, input key_event_t typed);
    row_t row;
    row.rpt.len   = len;
    row.rpt.mods  = mods;
    row.rpt.slots = {s5, s4, s3, s2, s1, s0};
    row.how       = how;
    row.typed     = typed;
    directed_rows.push_back(row);
  endtask

  function automatic logic [7:0] pick_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 2))
        0:       return CodeCaps;
        1:       return CodeScroll;
        default: return CodeNum;
      endcase
    end
    if (r < 45) return 8'($urandom_range(4, 56));
    if (r < 62) return 8'($urandom_range(58, 82));   // F keys, navigation, editing
    if (r < 82) return 8'($urandom_range(PadFirst, PadLast));
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] pick_mods();
    case ($urandom_range(0, 11))
      0, 1:    return 8'h00;
      2:       return 8'h02;
      3:       return 8'h20;
      4:       return 8'h01;
      5:       return 8'h10;
      6:       return 8'h04;
      7:       return 8'h80;
      8:       return 8'h22;
      9:       return 8'h03;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_report(input report_t rpt, input chk_e how, input key_event_t typed);
    int unsigned idle;
    idle = next_gap(src_calm);
    if (idle != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, rpt};
    do @(posedge clk_i); while (!s_axis_tready_o);
    decode_report(rpt, how == CHK_MODEL);
    if (how == CHK_ONE) pending_events.push_back(typed);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      failed = 1'b1;
    end
  endtask

  // sink side: ready changes on the falling edge
  initial begin : event_sink
    m_axis_tready_i = 1'b0;
    sink_hold = 0;
    sink_calm = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold != 0) begin
        m_axis_tready_i <= 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready_i <= 1'b1;
        sink_hold = next_gap(sink_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_ev = {m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tdata_o[15:8],
                m_axis_tdata_o[23:16], m_axis_tdata_o[26:24], m_axis_tdata_o[27],
                m_axis_tlast_o};
      if (pending_events.size() == 0) begin
        $error("unexpected event: kind %0d raw_code 0x%0h", got_ev.event_kind,
               got_ev.raw_code);
        failed = 1'b1;
      end else begin
        want_ev = pending_events.pop_front();
        check_field("event_kind", want_ev.event_kind, got_ev.event_kind);
        check_field("raw_code", want_ev.raw_code, got_ev.raw_code);
        check_field("mapped_char", want_ev.mapped_char, got_ev.mapped_char);
        check_field("modifier_used", want_ev.modifier_used, got_ev.modifier_used);
        check_field("lock_leds", want_ev.lock_leds, got_ev.lock_leds);
        check_field("leds_changed", want_ev.leds_changed, got_ev.leds_changed);
        check_field("last_event", want_ev.last_event, got_ev.last_event);
      end
    end
  end

  initial begin : report_source
    report_t     rpt;
    int unsigned r;
    int unsigned valid_sent;
    logic [7:0]  code;
    logic [7:0]  mods_now;
    bit          dup;
    failed          = 1'b0;
    src_calm        = 0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    rst_ni          = 1'b0;
    prev_keys       = '0;
    prev_mods       = 8'h00;
    lock_leds_q     = 3'b000;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first press and release after reset
    add_row(8, 'h00, 'h04, 0, 0, 0, 0, 0, CHK_ONE,
            single_event(EvPress, 'h04, 'h61, 'h00, 3'b000, 1'b0));
    add_row(8, 'h00, 0, 0, 0, 0, 0, 0, CHK_ONE,
            single_event(EvRelease, 'h04, 'h61, 'h00, 3'b000, 1'b0));
    // bad lengths are dropped
    add_row(0, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, CHK_NONE, '0);
    add_row(64, 'h5A, 'h39, 'h47, 'h53, 0, 0, 0, CHK_NONE, '0);
    add_row(7, 'h00, 'h04, 0, 0, 0, 0, 0, CHK_NONE, '0);
    add_row(10, 'h00, 'h04, 0, 0, 0, 0, 0, CHK_NONE, '0);
    add_row(9, 'h02, 'h04, 0, 0, 0, 0, 0, CHK_ONE,
            single_event(EvPress, 'h04, 'h41, 'h02, 3'b000, 1'b0));
    add_row(9, 'h00, 0, 0, 0, 0, 0, 0, CHK_MODEL, '0);
    // caps lock usage lies past the keymap
    add_row(8, 'h00, CodeCaps, 0, 0, 0, 0, 0, CHK_ONE,
            single_event(EvPress, CodeCaps, 'h00, 'h00, 3'b000, 1'b0));
    add_row(8, 'h00, 0, 0, 0, 0, 0, 0, CHK_ONE,
            single_event(EvRelease, CodeCaps, 'h00, 'h00, LockCaps, 1'b1));
    add_row(8, 'h00, 'h04, 0, 0, 0, 0, 0, CHK_MODEL, '0);
    add_row(8, 'h20, 'h05, 0, 0, 0, 0, 0, CHK_MODEL, '0);
    add_row(8, 'h00, CodeCaps, 0, 0, 0, 0, 0, CHK_MODEL, '0);
    add_row(8, 'h00, 0, 0, 0, 0, 0, 0, CHK_MODEL, '0);
    // num lock, then keypad both ways, then scroll lock
    add_row(8, 'h00, CodeNum, 0, 0, 0, 0, 0, CHK_MODEL, '0);
    add_row(8, 'h00, 'h5A, 0, 0, 0, 0, 0, CHK_MODEL, '0);
    add_row(8, 'h00, 'h5A, 'h5D, 0, 0, 0, 0, CHK_MODEL, '0);
    add_row(8, 'h00, CodeScroll, 0, 0, 0, 0, 0, CHK_MODEL, '0);
    add_row(8, 'h00, 0, 0, 0, 0, 0, 0, CHK_MODEL, '0);
    // ctrl+shift and alt give no keymap character; F1 still maps with alt down
    add_row(8, 'h03, 'h04, 0, 0, 0, 0, 0, CHK_MODEL, '0);
    add_row(8, 'h44, 'h06, 'h3A, 0, 0, 0, 0, CHK_MODEL, '0);
    // scan stops at the first empty slot; repeat it unchanged with a new modifier
    add_row(8, 'h10, 'h07, 0, 'h08, 'h09, 0, 0, CHK_MODEL, '0);
    add_row(9, 'h01, 'h07, 0, 'h08, 'h09, 0, 0, CHK_MODEL, '0);
    add_row(8, 'hFF, 'hFF, 'h2C, 'h29, 'h45, 'h28, 'h01, CHK_MODEL, '0);
    // six presses plus six releases
    add_row(8, 'h80, 'h04, 'h05, 'h06, 'h2B, 'h63, 'h54, CHK_MODEL, '0);
    add_row(8, 'h00, 'h09, 'h09, 0, 0, 0, 0, CHK_MODEL, '0);

    for (int i = 0; i < directed_rows.size(); i++)
      send_report(directed_rows[i].rpt, directed_rows[i].how, directed_rows[i].typed);

    held_keys.delete();
    for (int k = 0; k < KeySlots; k++) begin
      if (prev_keys[k] == 8'h00) break;
      held_keys.push_back(prev_keys[k]);
    end
    mods_now   = prev_mods;
    valid_sent = 0;
    while (valid_sent < 270) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // wrong length, random content
        do rpt.len = 7'($urandom_range(0, 64));
        while (rpt.len == LenBoot || rpt.len == LenBootId);
        rpt.mods  = 8'($urandom_range(0, 255));
        rpt.slots = 48'({$urandom, $urandom});
      end else if (r < 24) begin
        // arbitrary slot bytes, holes anywhere
        rpt.len  = $urandom_range(0, 1) ? LenBoot : LenBootId;
        rpt.mods = 8'($urandom_range(0, 255));
        for (int k = 0; k < KeySlots; k++)
          rpt.slots[k] = ($urandom_range(0, 99) < 25) ? 8'h00 : 8'($urandom_range(0, 255));
        mods_now = rpt.mods;
        held_keys.delete();
        for (int k = 0; k < KeySlots; k++) begin
          if (rpt.slots[k] == 8'h00) break;
          held_keys.push_back(rpt.slots[k]);
        end
        valid_sent++;
      end else begin
        // typing: keys go down and come up one at a time, now and then all at once
        if ($urandom_range(0, 99) < 6) held_keys.delete();
        if (held_keys.size() != 0 && $urandom_range(0, 99) < 45)
          held_keys.delete($urandom_range(0, held_keys.size() - 1));
        if (held_keys.size() < KeySlots && $urandom_range(0, 99) < 60) begin
          code = pick_code();
          dup  = 1'b0;
          for (int k = 0; k < held_keys.size(); k++)
            if (held_keys[k] == code) dup = 1'b1;
          if (!dup) held_keys.push_back(code);
        end
        if ($urandom_range(0, 99) < 35) mods_now = pick_mods();
        rpt.len   = $urandom_range(0, 1) ? LenBoot : LenBootId;
        rpt.mods  = mods_now;
        rpt.slots = '0;
        for (int k = 0; k < held_keys.size(); k++) rpt.slots[k] = held_keys[k];
        valid_sent++;
      end
      send_report(rpt, CHK_MODEL, '0);
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (!failed) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/hbkd_pkg.sv
design/hbkd_match.sv
design/hbkd_mapper.sv
design/hid_boot_keyboard_report_decoder_unit.sv
test/tb_hid_boot_keyboard_report_decoder_unit.sv
